// ===== rtl/pspl_pkg.sv =====
// ----------------------------------------------------------------------------
// pspl_pkg
// Shared types and constants for the PAT section PMT PID lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pspl_pkg;

    localparam int MAX_SECTION_BYTES = 4096;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 12;
    localparam int ID_W     = 16;
    localparam int PID_W    = 13;
    localparam int PID_HI_W = 5;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = LEN_W + 2;   // holds length + 3 and position + 2

    // header byte positions
    localparam int POS_LEN_HI   = 1;
    localparam int POS_LEN_LO   = 2;
    localparam int POS_SID_HI   = 3;
    localparam int POS_SID_LO   = 4;
    localparam int ENTRY_START  = 8;  // multiple of 4: entry phase is pos[1:0]
    localparam int CRC_TAIL     = 2;  // entry end must be <= length - 2
    localparam int HDR_OVERHEAD = 3;  // bytes not counted by the length field

    localparam logic [BYTE_W-1:0] LEN_HI_MASK = 8'h0f;

    // entry phases
    localparam logic [1:0] PH_PROG_HI = 2'd0;
    localparam logic [1:0] PH_PROG_LO = 2'd1;
    localparam logic [1:0] PH_PID_HI  = 2'd2;
    localparam logic [1:0] PH_PID_LO  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STREAM  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE   = 1'd1;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [PID_W-1:0]    pid;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/pspl_in_stage.sv =====
// ----------------------------------------------------------------------------
// pspl_in_stage
// Input register: captures one section byte word per cycle unless the held word is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pspl_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pspl_pkg::item_t s_item,
    input  wire logic            advance,
    output logic                 item_valid,
    output pspl_pkg::item_t      item
);

    logic            valid_reg, valid_next;
    pspl_pkg::item_t item_reg;
    logic            accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/pspl_core.sv =====
// ----------------------------------------------------------------------------
// pspl_core
// Section parse state: header fields, entry scan and end-of-section status.
// ----------------------------------------------------------------------------
`default_nettype none

module pspl_core
#(
    parameter int MAX_SECTION_BYTES = pspl_pkg::MAX_SECTION_BYTES
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire pspl_pkg::item_t             item,
    input  wire logic [pspl_pkg::ID_W-1:0]   wanted_stream_id,
    input  wire logic [pspl_pkg::ID_W-1:0]   wanted_service,
    output pspl_pkg::result_t                result
);

    localparam int POS_W = $clog2(MAX_SECTION_BYTES + 1);
    localparam int CMP_W = pspl_pkg::CMP_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SECTION_BYTES);

    logic [POS_W-1:0]                pos_reg, pos_next, count;
    logic [pspl_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [pspl_pkg::ID_W-1:0]       sid_reg, sid_next;
    logic [pspl_pkg::ID_W-1:0]       prog_reg, prog_next;
    logic [pspl_pkg::PID_HI_W-1:0]   pid_hi_reg, pid_hi_next;
    logic                            found_reg, found_next;
    logic [pspl_pkg::PID_W-1:0]      fpid_reg, fpid_next;
    logic                            overrun;
    logic                            entry_in_bounds;
    logic [pspl_pkg::BYTE_W-1:0]     b;

    assign b       = item.data;
    // position pins at the max; any further byte is an overrun
    assign overrun = (pos_reg == POS_MAX);
    assign count   = overrun ? POS_MAX : pos_reg + 1'b1;
    assign entry_in_bounds = (CMP_W'(pos_reg) + CMP_W'(pspl_pkg::CRC_TAIL))
                             <= CMP_W'(len_reg);

    always_comb
    begin
        pos_next    = overrun ? pos_reg : pos_reg + 1'b1;
        len_next    = len_reg;
        sid_next    = sid_reg;
        prog_next   = prog_reg;
        pid_hi_next = pid_hi_reg;
        found_next  = found_reg;
        fpid_next   = fpid_reg;
        if (!overrun)
        begin
            case (pos_reg)
                POS_W'(pspl_pkg::POS_LEN_HI):
                    len_next[11:8] = b[3:0] & pspl_pkg::LEN_HI_MASK[3:0];
                POS_W'(pspl_pkg::POS_LEN_LO):
                    len_next[7:0] = b;
                POS_W'(pspl_pkg::POS_SID_HI):
                    sid_next[15:8] = b;
                POS_W'(pspl_pkg::POS_SID_LO):
                    sid_next[7:0] = b;
                default:
                begin
                    if (pos_reg >= POS_W'(pspl_pkg::ENTRY_START))
                    begin
                        case (pos_reg[1:0])
                            pspl_pkg::PH_PROG_HI: prog_next = {b, 8'h00};
                            pspl_pkg::PH_PROG_LO: prog_next[7:0] = b;
                            pspl_pkg::PH_PID_HI:
                                pid_hi_next = b[pspl_pkg::PID_HI_W-1:0];
                            pspl_pkg::PH_PID_LO:
                            begin
                                // first in-bounds match wins
                                if (!found_reg && entry_in_bounds &&
                                    prog_reg == wanted_service)
                                begin
                                    found_next = 1'b1;
                                    fpid_next  = {pid_hi_reg, b};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.pid = '0;
        if (overrun || (CMP_W'(count) !=
                        CMP_W'(len_next) + CMP_W'(pspl_pkg::HDR_OVERHEAD)))
            result.status = pspl_pkg::ST_SIZE;
        else if (sid_next != wanted_stream_id)
            result.status = pspl_pkg::ST_STREAM;
        else if (found_next)
        begin
            result.status = pspl_pkg::ST_FOUND;
            result.pid    = fpid_next;
        end
        else
            result.status = pspl_pkg::ST_MISSING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            sid_reg    <= '0;
            prog_reg   <= '0;
            pid_hi_reg <= '0;
            found_reg  <= 1'b0;
            fpid_reg   <= '0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                pos_reg    <= '0;
                len_reg    <= '0;
                sid_reg    <= '0;
                prog_reg   <= '0;
                pid_hi_reg <= '0;
                found_reg  <= 1'b0;
                fpid_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                sid_reg    <= sid_next;
                prog_reg   <= prog_next;
                pid_hi_reg <= pid_hi_next;
                found_reg  <= found_next;
                fpid_reg   <= fpid_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pspl_out_stage.sv =====
// ----------------------------------------------------------------------------
// pspl_out_stage
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pspl_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire pspl_pkg::result_t result,
    output logic                   room,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output pspl_pkg::result_t      m_result
);

    logic              valid_reg, valid_next;
    pspl_pkg::result_t result_reg;

    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/pat_section_pmt_pid_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// pat_section_pmt_pid_lookup_unit
// PAT section parser that returns the PMT PID of one configured service.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries the section one byte per word, tlast on the final
//   byte. Master stream carries one result word per section, issued for the
//   tlast byte: status (found / size mismatch / stream id mismatch / not
//   found) and the PMT PID (zero unless found).
//   Config port: cfg_we with cfg_index 0 = wanted stream id, 1 = wanted
//   service id. Write only while no section is in flight.
//   Result: computed from the tlast byte held in the input register, then
//   registered. Throughput: one byte per cycle sustained unless a tlast byte
//   waits on a stalled result; one pass per byte, input register to parse state.
//   Receiver stall: the result register holds; non-last bytes keep flowing,
//   and the next tlast byte waits in the input register, holding s_tready
//   low, until the pending result is taken.
//   Reset: clears both stream stages, the parse state and the config regs.
//   Bytes past MAX_SECTION_BYTES are dropped and force a size mismatch.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_section_pmt_pid_lookup_unit
#(
    parameter int MAX_SECTION_BYTES = pspl_pkg::MAX_SECTION_BYTES
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] section_byte
    input  wire logic                             s_tlast,  // last_byte
    // master stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [15:0]                           m_tdata,  // [1:0] status,
                                                            // [14:2] pmt_pid,
                                                            // [15] zero
    // config write port
    input  wire logic                             cfg_we,
    input  wire logic [pspl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pspl_pkg::ID_W-1:0]        cfg_data
);

    logic [pspl_pkg::ID_W-1:0] stream_id_reg;
    logic [pspl_pkg::ID_W-1:0] service_reg;

    pspl_pkg::item_t   s_item, item;
    pspl_pkg::result_t result, m_result;
    logic              item_valid;
    logic              advance;
    logic              room;
    logic              load;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_id_reg <= '0;
            service_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pspl_pkg::CFG_STREAM_ID: stream_id_reg <= cfg_data;
                pspl_pkg::CFG_SERVICE:   service_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_item.data = s_tdata;
    assign s_item.last = s_tlast;

    // a non-last byte never needs the result register
    assign advance = item_valid && (!item.last || room);
    assign load    = advance && item.last;

    pspl_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pspl_core
    #(
        .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
    )
    u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (advance),
        .item             (item),
        .wanted_stream_id (stream_id_reg),
        .wanted_service   (service_reg),
        .result           (result)
    );

    pspl_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {1'b0, m_result.pid, m_result.status};

`ifndef SYNTHESIS
    // PID is reported only with a found status
    a_pid_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_result.status != pspl_pkg::ST_FOUND) |-> (m_result.pid == '0))
        else $error("pmt_pid nonzero without found status");

    // input backpressure only comes from a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && item_valid && item.last))
        else $error("s_tready low without a stalled result");

    // a result is loaded only from a tlast byte
    a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(item_valid && item.last))
        else $error("result appeared without a last byte");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PAT section PMT PID lookup unit.
// Sections are built byte by byte (well-formed tables, truncated and padded
// ones, partial entries, header-only shorts, a long length field sent short
// and raw noise), pushed through the slave stream in random bursts and
// checked against a local section parser at the master stream, one result
// word per section.
// ----------------------------------------------------------------------------

module tb;

    // ------------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;

    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;   // [7:0] section_byte
    logic                           s_tlast   = 1'b0; // last_byte

    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [15:0]                    m_tdata;  // [1:0] status, [14:2] pmt_pid, [15] zero

    logic                           cfg_we    = 1'b0;
    logic [pspl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pspl_pkg::ID_W-1:0]      cfg_data  = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pat_section_pmt_pid_lookup_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // parser mirror: lookup registers and per-section state
    // ------------------------------------------------------------------------
    logic [pspl_pkg::ID_W-1:0]     want_sid      = '0;
    logic [pspl_pkg::ID_W-1:0]     want_svc      = '0;

    int                            sec_pos       = 0;   // bytes taken before this one
    logic [pspl_pkg::LEN_W-1:0]    sec_len       = '0;  // length field from header
    logic [pspl_pkg::ID_W-1:0]     sec_sid       = '0;  // stream id from header
    logic [pspl_pkg::ID_W-1:0]     sec_prog      = '0;  // program number of current entry
    logic [pspl_pkg::PID_HI_W-1:0] sec_pid_hi    = '0;
    bit                            sec_found     = 1'b0;
    logic [pspl_pkg::PID_W-1:0]    sec_found_pid = '0;
    bit                            sec_overrun   = 1'b0;

    pspl_pkg::item_t               section_words[$];  // words waiting for the driver
    pspl_pkg::result_t             lookups_due[$];    // predicted result words, oldest first
    logic [7:0]                    sec_buf[$];        // section under construction
    int                            queued_words  = 0;
    int                            results_seen  = 0;
    int                            mismatches    = 0;

    // Advance the mirror by one accepted byte; returns 1 with the lookup
    // result when the byte closes the section.
    function automatic bit parse_byte(input pspl_pkg::item_t w,
                                      output pspl_pkg::result_t r);
        int count;
        int ph;
        r = '0;
        if (sec_overrun || sec_pos >= pspl_pkg::MAX_SECTION_BYTES)
        begin
            // past the byte budget: drop the byte, remember the overrun
            sec_overrun = 1'b1;
            count       = pspl_pkg::MAX_SECTION_BYTES;
        end
        else
        begin
            case (sec_pos)
                pspl_pkg::POS_LEN_HI:
                    sec_len[11:8] = w.data[3:0] & pspl_pkg::LEN_HI_MASK[3:0];
                pspl_pkg::POS_LEN_LO: sec_len[7:0]  = w.data;
                pspl_pkg::POS_SID_HI: sec_sid[15:8] = w.data;
                pspl_pkg::POS_SID_LO: sec_sid[7:0]  = w.data;
                default:
                begin
                    if (sec_pos >= pspl_pkg::ENTRY_START)
                    begin
                        ph = (sec_pos - pspl_pkg::ENTRY_START) % 4;
                        if (ph == pspl_pkg::PH_PROG_HI)
                            sec_prog = {w.data, 8'h00};
                        else if (ph == pspl_pkg::PH_PROG_LO)
                            sec_prog[7:0] = w.data;
                        else if (ph == pspl_pkg::PH_PID_HI)
                            sec_pid_hi = w.data[pspl_pkg::PID_HI_W-1:0];
                        else if (!sec_found &&
                                 sec_pos + pspl_pkg::CRC_TAIL <= int'(sec_len) &&
                                 sec_prog == want_svc)
                        begin
                            // entry lies fully before the CRC: first match wins
                            sec_found     = 1'b1;
                            sec_found_pid = {sec_pid_hi, w.data};
                        end
                    end
                end
            endcase
            count   = sec_pos + 1;
            sec_pos = (count < pspl_pkg::MAX_SECTION_BYTES) ? count
                                                            : pspl_pkg::MAX_SECTION_BYTES;
        end

        if (!w.last)
            return 1'b0;

        // size beats stream id beats found / not found
        if (sec_overrun || count != int'(sec_len) + pspl_pkg::HDR_OVERHEAD)
            r.status = pspl_pkg::ST_SIZE;
        else if (sec_sid != want_sid)
            r.status = pspl_pkg::ST_STREAM;
        else if (sec_found)
        begin
            r.status = pspl_pkg::ST_FOUND;
            r.pid    = sec_found_pid;
        end
        else
            r.status = pspl_pkg::ST_MISSING;

        sec_pos       = 0;
        sec_len       = '0;
        sec_sid       = '0;
        sec_prog      = '0;
        sec_pid_hi    = '0;
        sec_found     = 1'b0;
        sec_found_pid = '0;
        sec_overrun   = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0h, wanted %0h at %0t ns", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // section builders
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] v);
        sec_buf.insert(sec_buf.size(), v);
    endtask

    // Header: table id, length (random reserved nibble on top), stream id,
    // version / section number / last section number as random filler.
    task automatic start_section(input logic [pspl_pkg::LEN_W-1:0] len,
                                 input logic [pspl_pkg::ID_W-1:0] sid);
        logic [3:0] nib;
        nib = 4'($urandom);
        sec_buf.delete();
        put_byte(8'h00);
        put_byte({nib, len[11:8]});
        put_byte(len[7:0]);
        put_byte(sid[15:8]);
        put_byte(sid[7:0]);
        repeat (3) put_byte(8'($urandom));
    endtask

    task automatic add_entry(input logic [pspl_pkg::ID_W-1:0] prog,
                             input logic [pspl_pkg::PID_W-1:0] pid);
        logic [2:0] rsv;
        rsv = 3'($urandom);
        put_byte(prog[15:8]);
        put_byte(prog[7:0]);
        put_byte({rsv, pid[12:8]});
        put_byte(pid[7:0]);
    endtask

    task automatic add_crc(input bit ones);
        repeat (4) put_byte(ones ? 8'hff : 8'($urandom));
    endtask

    // Hand the built section to the driver; adjust < 0 truncates, > 0 pads.
    task automatic send_section(input int adjust);
        pspl_pkg::item_t w;
        if (adjust < 0)
        begin
            repeat (-adjust)
                if (sec_buf.size() > 1)
                    void'(sec_buf.pop_back());
        end
        else
        begin
            repeat (adjust) put_byte(8'($urandom));
        end
        foreach (sec_buf[i])
        begin
            w.data = sec_buf[i];
            w.last = (i == sec_buf.size() - 1);
            section_words.insert(section_words.size(), w);
        end
        queued_words += sec_buf.size();
    endtask

    // Mostly well-formed tables with random content; some partial entries,
    // wrong sizes and raw noise.
    task automatic queue_random_section();
        int kind;
        int n;
        int p;
        logic [pspl_pkg::ID_W-1:0] sid;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            sec_buf.delete();
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom));
            send_section(0);
        end
        else
        begin
            n   = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            p   = (kind < 20) ? $urandom_range(1, 3) : 0;
            sid = ($urandom_range(0, 4) == 0) ? 16'($urandom) : want_sid;
            start_section(12'(9 + 4 * n + p), sid);
            repeat (n) add_entry(($urandom_range(0, 2) == 0) ? want_svc : 16'($urandom),
                                 13'($urandom));
            // partial entry carrying the wanted program number
            if (p >= 1) put_byte(want_svc[15:8]);
            if (p >= 2) put_byte(want_svc[7:0]);
            if (p >= 3) put_byte(8'($urandom));
            add_crc($urandom_range(0, 9) == 0);
            if (kind >= 20 && kind < 30)
                send_section(($urandom_range(0, 1) == 0) ? -int'($urandom_range(1, 3))
                                                         : int'($urandom_range(1, 3)));
            else
                send_section(0);
        end
    endtask

    task automatic run_random_phase();
        int secs;
        int start_words;
        secs        = 0;
        start_words = queued_words;
        while (secs < 5 || queued_words - start_words < 120)
        begin
            queue_random_section();
            secs++;
        end
    endtask

    // Wait until every byte is taken and every result is back, then a few
    // more cycles for the result stage to go quiet.
    task automatic drain(input int extra);
        while (section_words.size() != 0 || s_tvalid || lookups_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Lookup registers are only touched while the unit is idle.
    task automatic set_lookup(input logic [pspl_pkg::ID_W-1:0] sid,
                              input logic [pspl_pkg::ID_W-1:0] svc);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= pspl_pkg::CFG_STREAM_ID;
        cfg_data  <= sid;
        want_sid   = sid;
        @(posedge clk);
        cfg_index <= pspl_pkg::CFG_SERVICE;
        cfg_data  <= svc;
        want_svc   = svc;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // slave side driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int                burst_left = 0;
    int                gap_left   = 0;
    pspl_pkg::item_t   next_word;
    pspl_pkg::result_t next_lookup;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // word taken this edge: run it through the mirror
            if (s_tvalid && s_tready)
            begin
                if (parse_byte(pspl_pkg::item_t'{last: s_tlast, data: s_tdata},
                               next_lookup))
                    lookups_due.insert(lookups_due.size(), next_lookup);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (section_words.size() != 0)
                begin
                    next_word = section_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.data;
                    s_tlast  <= next_word.last;
                    if (burst_left <= 1)
                    begin
                        // burst over: pick the next one, a third of them back to back
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // master side ready: its own stall pattern plus one long hold-off
    // ------------------------------------------------------------------------
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            ready_mode <= 0;
            mode_left  <= 0;
            stall_tick <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 12)
        begin
            // long hold-off while the sender keeps offering sections:
            // result register fills, next tlast byte backs up the input
            m_tready  <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(10, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_tick % 5 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each result word against the oldest prediction
    // ------------------------------------------------------------------------
    pspl_pkg::result_t due_lookup;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lookups_due.size() == 0)
                report_mismatch("result word with none pending", int'(m_tdata), 0);
            else
            begin
                due_lookup = lookups_due.pop_front();
                if (m_tdata[1:0] != due_lookup.status)
                    report_mismatch("status", int'(m_tdata[1:0]), int'(due_lookup.status));
                if (m_tdata[14:2] != due_lookup.pid)
                    report_mismatch("pmt_pid", int'(m_tdata[14:2]), int'(due_lookup.pid));
            end
            results_seen <= results_seen + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset lookup values (stream id 0, service 0)
        // header-only section with length 0: right size, nothing to find
        sec_buf.delete();
        put_byte(8'h00);
        put_byte(8'hf0);
        put_byte(8'h00);
        send_section(0);
        // lone byte: unread header reads zero, size is off
        sec_buf.delete();
        put_byte(8'($urandom));
        send_section(0);
        // match on program 0 with PID 0 still counts as found
        start_section(12'd13, 16'h0000);
        add_entry(16'h0000, 13'h0000);
        add_crc(1'b0);
        send_section(0);
        drain(4);

        set_lookup(16'hffff, 16'hffff);
        // match on the last entry before the CRC, all PID bits set
        start_section(12'd17, 16'hffff);
        add_entry(16'h1234, 13'($urandom));
        add_entry(16'hffff, 13'h1fff);
        add_crc(1'b0);
        send_section(0);
        // two matches: first one kept
        start_section(12'd17, 16'hffff);
        add_entry(16'hffff, 13'h0abc);
        add_entry(16'hffff, 13'h1555);
        add_crc(1'b0);
        send_section(0);
        // wrong stream id hides a match
        start_section(12'd13, 16'hfffe);
        add_entry(16'hffff, 13'h0001);
        add_crc(1'b0);
        send_section(0);
        // no match; CRC bytes that look like the wanted program are out of bounds
        start_section(12'd13, 16'hffff);
        add_entry(16'h0000, 13'h0005);
        add_crc(1'b1);
        send_section(0);
        // one byte short, then two bytes long
        start_section(12'd13, 16'hffff);
        add_entry(16'hffff, 13'h0007);
        add_crc(1'b0);
        send_section(-1);
        start_section(12'd13, 16'hffff);
        add_entry(16'hffff, 13'h0007);
        add_crc(1'b0);
        send_section(2);
        // partial entry with the wanted program running into the CRC
        start_section(12'd16, 16'hffff);
        add_entry(16'h1234, 13'($urandom));
        put_byte(8'hff);
        put_byte(8'hff);
        put_byte(8'h1f);
        add_crc(1'b0);
        send_section(0);
        // length field with the high nibble set, section sent far too short
        start_section(12'h10d, 16'hffff);
        add_entry(16'hffff, 13'h0f0f);
        add_crc(1'b0);
        send_section(0);
        drain(4);

        // random phases under several lookup settings
        set_lookup(16'($urandom), 16'($urandom));
        run_random_phase();
        drain(4);

        set_lookup(16'h0000, 16'hffff);
        run_random_phase();
        drain(4);

        set_lookup(16'($urandom), 16'($urandom));
        run_random_phase();
        drain(20);

        if (lookups_due.size() != 0)
            report_mismatch("results never delivered", 0, lookups_due.size());

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
